[hdl/noc_ni_pkg.sv]
`timescale 1ns / 1ps
// Package for the NoC network interface: shared constants, register codes
// and the control/status structs between the FIFO controllers and the top.
// No dependencies.
package noc_ni_pkg;

  localparam int FIFO_DEPTH_DEF   = 8;
  localparam int PAYLOAD_BITS_DEF = 22;
  localparam int FLIT_BITS        = 32;
  localparam int COORD_BITS       = 2;
  localparam int CFG_IDX_BITS     = 2;
  localparam int HDR_BITS         = 10;

  localparam logic [1:0] FLIT_TYPE = 2'b01;

  localparam logic [CFG_IDX_BITS-1:0] CFG_LOCAL_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOCAL_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEST_X  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEST_Y  = 2'd3;

  typedef struct packed {
    logic fire;
    logic pop_req;
    logic push_req;
  } fifo_req_t;

  typedef struct packed {
    logic pop;
    logic not_full;
  } fifo_stat_t;

endpackage

[hdl/noc_ni_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the NoC network interface: the tick
// word going in and the result word coming out. Depends on noc_ni_pkg.
interface noc_ni_in_if import noc_ni_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    pe_valid;
  logic [PAYLOAD_BITS-1:0] pe_data;
  logic                    router_valid;
  logic [FLIT_BITS-1:0]    flit_in;
  logic                    router_ready;
  logic                    pe_ready;

  modport source (
    output valid, pe_valid, pe_data, router_valid, flit_in, router_ready, pe_ready,
    input  ready
  );
  modport sink (
    input  valid, pe_valid, pe_data, router_valid, flit_in, router_ready, pe_ready,
    output ready
  );
endinterface

interface noc_ni_out_if import noc_ni_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    flit_valid;
  logic [FLIT_BITS-1:0]    tx_flit;
  logic                    data_valid;
  logic [PAYLOAD_BITS-1:0] rx_data;
  logic                    pe_accept_ready;
  logic                    router_accept_ready;

  modport source (
    output valid, flit_valid, tx_flit, data_valid, rx_data, pe_accept_ready,
           router_accept_ready,
    input  ready
  );
  modport sink (
    input  valid, flit_valid, tx_flit, data_valid, rx_data, pe_accept_ready,
           router_accept_ready,
    output ready
  );
endinterface

[hdl/noc_ni_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module noc_ni_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/noc_ni_fifo_ctl.sv]
`timescale 1ns / 1ps
// FIFO controller: pointers and count around one noc_ni_ram, with head
// forwarding for a write that lands on the entry being read.
// Depends on noc_ni_pkg and noc_ni_ram.
module noc_ni_fifo_ctl import noc_ni_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  fifo_req_t        req,
  input  logic [WIDTH-1:0] wdata,
  output fifo_stat_t       stat,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [PW-1:0]    head;
  logic [PW-1:0]    head_next;
  logic [PW-1:0]    tail;
  logic [PW-1:0]    tail_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    count_mid;
  logic             pop;
  logic             push;
  logic             fwd_valid;
  logic [WIDTH-1:0] fwd_data;
  logic [WIDTH-1:0] rdata;

  always_comb begin
    pop        = req.fire && req.pop_req && (count != '0);
    count_mid  = count - CW'(pop);
    push       = req.fire && req.push_req && (count_mid != FULL);
    count_next = count_mid + CW'(push);
    head_next  = head;
    if (pop) begin
      head_next = (head == LAST) ? '0 : head + 1'b1;
    end
    tail_next = tail;
    if (push) begin
      tail_next = (tail == LAST) ? '0 : tail + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      fwd_valid <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      fwd_valid <= push && (tail == head_next);
    end
    fwd_data <= wdata;
  end

  noc_ni_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (push),
    .waddr(tail),
    .wdata(wdata),
    .raddr(head_next),
    .rdata(rdata)
  );

  assign head_data     = fwd_valid ? fwd_data : rdata;
  assign stat.pop      = pop;
  assign stat.not_full = (count_next != FULL);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("fifo count beyond depth");
  a_count_reset: assert property (@(posedge clk) $past(rst) |-> count == '0)
    else $error("fifo count not cleared by reset");
  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !req.fire |=> $stable(count) && $stable(head))
    else $error("fifo moved without a word");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) || (count == FULL) || (head != tail))
    else $error("pointers disagree with count");
`endif

endmodule

[hdl/noc_ni_out_buf.sv]
`timescale 1ns / 1ps
// Output register plus skid stage for the result word, so a new word is
// taken while the previous one waits downstream. No dependencies.
module noc_ni_out_buf #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             enq_valid,
  output logic             enq_ready,
  input  logic [WIDTH-1:0] enq_data,
  output logic             deq_valid,
  input  logic             deq_ready,
  output logic [WIDTH-1:0] deq_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             enq_fire;
  logic             hold;

  assign enq_ready = !skid_valid;
  assign enq_fire  = enq_valid && enq_ready;
  assign hold      = deq_valid && !deq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      deq_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (hold) begin
      if (enq_fire) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      deq_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      deq_valid <= enq_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (hold) begin
      if (enq_fire) begin
        skid_data <= enq_data;
      end
    end else if (skid_valid) begin
      deq_data <= skid_data;
    end else if (enq_fire) begin
      deq_data <= enq_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> deq_valid)
    else $error("skid word without output word");
`endif

endmodule

[hdl/noc_network_interface_unit.sv]
`timescale 1ns / 1ps
// NoC network interface: one tick word in, one result word out, one word per
// cycle while results are taken. A result is registered in the output register
// as its tick word is accepted, or in the skid register while one waits; the
// two-deep output stage keeps input open. Each FIFO's RAM is read at the next
// head address. Reset clears counts, pointers and coordinates, not the RAM.
module noc_network_interface_unit import noc_ni_pkg::*; #(
  parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  noc_ni_in_if.sink               tick_ch,
  noc_ni_out_if.source            res_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_wdata
);

  localparam int IW = (PAYLOAD_BITS < FLIT_BITS) ? PAYLOAD_BITS : FLIT_BITS;
  localparam int FW = PAYLOAD_BITS + HDR_BITS;
  localparam int RW = FLIT_BITS + PAYLOAD_BITS + 4;

  logic [COORD_BITS-1:0]   local_x;
  logic [COORD_BITS-1:0]   local_y;
  logic [COORD_BITS-1:0]   dest_x;
  logic [COORD_BITS-1:0]   dest_y;

  logic                    fire;
  fifo_req_t               out_req;
  fifo_req_t               in_req;
  fifo_stat_t              out_stat;
  fifo_stat_t              in_stat;
  logic [PAYLOAD_BITS-1:0] out_head;
  logic [IW-1:0]           in_head;

  logic [FW-1:0]              flit_full;
  logic [FW+FLIT_BITS-1:0]    flit_ext;
  logic [PAYLOAD_BITS+IW-1:0] data_ext;
  logic [FLIT_BITS-1:0]       flit_word;
  logic [PAYLOAD_BITS-1:0]    data_word;
  logic [RW-1:0]              res_in;
  logic [RW-1:0]              res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_x <= '0;
      local_y <= '0;
      dest_x  <= '0;
      dest_y  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_X: local_x <= cfg_wdata;
        CFG_LOCAL_Y: local_y <= cfg_wdata;
        CFG_DEST_X:  dest_x  <= cfg_wdata;
        CFG_DEST_Y:  dest_y  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign fire = tick_ch.valid && tick_ch.ready;

  assign out_req.fire     = fire;
  assign out_req.pop_req  = tick_ch.router_ready;
  assign out_req.push_req = tick_ch.pe_valid;
  assign in_req.fire      = fire;
  assign in_req.pop_req   = tick_ch.pe_ready;
  assign in_req.push_req  = tick_ch.router_valid;

  noc_ni_fifo_ctl #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(FIFO_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .req      (out_req),
    .wdata    (tick_ch.pe_data),
    .stat     (out_stat),
    .head_data(out_head)
  );

  noc_ni_fifo_ctl #(
    .WIDTH(IW),
    .DEPTH(FIFO_DEPTH)
  ) u_in_fifo (
    .clk      (clk),
    .rst      (rst),
    .req      (in_req),
    .wdata    (tick_ch.flit_in[IW-1:0]),
    .stat     (in_stat),
    .head_data(in_head)
  );

  always_comb begin
    flit_full = {FLIT_TYPE, local_x, local_y, dest_x, dest_y, out_head};
    flit_ext  = {{FLIT_BITS{1'b0}}, flit_full};
    data_ext  = {{PAYLOAD_BITS{1'b0}}, in_head};
    flit_word = out_stat.pop ? flit_ext[FLIT_BITS-1:0] : '0;
    data_word = in_stat.pop ? data_ext[PAYLOAD_BITS-1:0] : '0;
    res_in    = {out_stat.pop, flit_word, in_stat.pop, data_word,
                 out_stat.not_full, in_stat.not_full};
  end

  noc_ni_out_buf #(
    .WIDTH(RW)
  ) u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .enq_valid(tick_ch.valid),
    .enq_ready(tick_ch.ready),
    .enq_data (res_in),
    .deq_valid(res_ch.valid),
    .deq_ready(res_ch.ready),
    .deq_data (res_out)
  );

  assign res_ch.flit_valid          = res_out[RW-1];
  assign res_ch.tx_flit             = res_out[RW-2 -: FLIT_BITS];
  assign res_ch.data_valid          = res_out[PAYLOAD_BITS+2];
  assign res_ch.rx_data             = res_out[PAYLOAD_BITS+1 -: PAYLOAD_BITS];
  assign res_ch.pe_accept_ready     = res_out[1];
  assign res_ch.router_accept_ready = res_out[0];

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for noc_network_interface_unit: drives tick words, predicts
// both FIFOs and the flit header, and checks every result word in order.
// Depends on noc_ni_pkg, the noc_ni_in_if/noc_ni_out_if interfaces and the unit.
module tb;
  import noc_ni_pkg::*;

  localparam int DEPTH = FIFO_DEPTH_DEF;
  localparam int PW    = PAYLOAD_BITS_DEF;

  typedef struct packed {
    logic                 pe_valid;
    logic [PW-1:0]        pe_data;
    logic                 router_valid;
    logic [FLIT_BITS-1:0] flit_in;
    logic                 router_ready;
    logic                 pe_ready;
  } ni_tick_t;

  typedef struct packed {
    logic                 flit_valid;
    logic [FLIT_BITS-1:0] tx_flit;
    logic                 data_valid;
    logic [PW-1:0]        rx_data;
    logic                 pe_accept_ready;
    logic                 router_accept_ready;
  } ni_result_t;

  class ni_scoreboard;
    logic [COORD_BITS-1:0] local_x, local_y, dest_x, dest_y;
    logic [PW-1:0]         tx_words[$];
    logic [FLIT_BITS-1:0]  rx_flits[$];
    ni_result_t            expected_q[$];
    int                    mismatches;

    function new();
      local_x = '0;
      local_y = '0;
      dest_x = '0;
      dest_y = '0;
      mismatches = 0;
    endfunction

    function void set_coord(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] val);
      case (idx)
        CFG_LOCAL_X: local_x = val;
        CFG_LOCAL_Y: local_y = val;
        CFG_DEST_X:  dest_x = val;
        CFG_DEST_Y:  dest_y = val;
        default: ;
      endcase
    endfunction

    function void note_tick(ni_tick_t t);
      ni_result_t           r;
      logic [PW-1:0]        word;
      logic [FLIT_BITS-1:0] flit;
      r = '0;
      if (tx_words.size() > 0 && t.router_ready) begin
        word = tx_words.pop_front();
        r.flit_valid = 1'b1;
        r.tx_flit = {FLIT_TYPE, local_x, local_y, dest_x, dest_y, word};
      end
      if (rx_flits.size() > 0 && t.pe_ready) begin
        flit = rx_flits.pop_front();
        r.data_valid = 1'b1;
        r.rx_data = flit[PW-1:0];
      end
      if (tx_words.size() < DEPTH && t.pe_valid) tx_words.push_back(t.pe_data);
      if (rx_flits.size() < DEPTH && t.router_valid) rx_flits.push_back(t.flit_in);
      r.pe_accept_ready = tx_words.size() < DEPTH;
      r.router_accept_ready = rx_flits.size() < DEPTH;
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [FLIT_BITS-1:0] exp, logic [FLIT_BITS-1:0] got);
      if (exp !== got) begin
        $display("%0t ns: %s expected %h, got %h", $time, name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_result(ni_result_t got);
      ni_result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t ns: unexpected result word, got %h", $time, got);
        mismatches++;
      end else begin
        exp = expected_q.pop_front();
        cmp_field("flit_valid", FLIT_BITS'(exp.flit_valid), FLIT_BITS'(got.flit_valid));
        cmp_field("tx_flit", exp.tx_flit, got.tx_flit);
        cmp_field("data_valid", FLIT_BITS'(exp.data_valid), FLIT_BITS'(got.data_valid));
        cmp_field("rx_data", FLIT_BITS'(exp.rx_data), FLIT_BITS'(got.rx_data));
        cmp_field("pe_accept_ready", FLIT_BITS'(exp.pe_accept_ready),
                  FLIT_BITS'(got.pe_accept_ready));
        cmp_field("router_accept_ready", FLIT_BITS'(exp.router_accept_ready),
                  FLIT_BITS'(got.router_accept_ready));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0]   cfg_wdata;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_request;

  ni_scoreboard sb;

  noc_ni_in_if  tick_ch ();
  noc_ni_out_if res_ch ();

  noc_network_interface_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .tick_ch   (tick_ch),
    .res_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic ni_tick_t make_tick(logic pv, logic [PW-1:0] pd, logic rv,
                                         logic [FLIT_BITS-1:0] fi, logic rr, logic pr);
    ni_tick_t t;
    t.pe_valid = pv;
    t.pe_data = pd;
    t.router_valid = rv;
    t.flit_in = fi;
    t.router_ready = rr;
    t.pe_ready = pr;
    return t;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_coord(idx, val);
  endtask

  task automatic apply_coords(logic [1:0] lx, logic [1:0] ly, logic [1:0] dx, logic [1:0] dy);
    write_reg(CFG_LOCAL_X, lx);
    write_reg(CFG_LOCAL_Y, ly);
    write_reg(CFG_DEST_X, dx);
    write_reg(CFG_DEST_Y, dy);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic offer_tick(ni_tick_t t);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.pe_valid <= t.pe_valid;
    tick_ch.pe_data <= t.pe_data;
    tick_ch.router_valid <= t.router_valid;
    tick_ch.flit_in <= t.flit_in;
    tick_ch.router_ready <= t.router_ready;
    tick_ch.pe_ready <= t.pe_ready;
    @(posedge clk);
    while (tick_ch.ready !== 1'b1) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic end_burst();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = 90;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    ni_result_t got;
    if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got.flit_valid = res_ch.flit_valid;
      got.tx_flit = res_ch.tx_flit;
      got.data_valid = res_ch.data_valid;
      got.rx_data = res_ch.rx_data;
      got.pe_accept_ready = res_ch.pe_accept_ready;
      got.router_accept_ready = res_ch.router_accept_ready;
      sb.check_result(got);
    end
  end

  initial begin
    ni_tick_t t;
    int       pct_levels[3];
    int       pv_pct, rv_pct, rr_pct, pr_pct;
    sb = new();
    pct_levels = '{5, 50, 95};
    pv_pct = 50;
    rv_pct = 50;
    rr_pct = 50;
    pr_pct = 50;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_LOCAL_X;
    cfg_wdata = '0;
    tick_ch.valid = 1'b0;
    tick_ch.pe_valid = 1'b0;
    tick_ch.pe_data = '0;
    tick_ch.router_valid = 1'b0;
    tick_ch.flit_in = '0;
    tick_ch.router_ready = 1'b0;
    tick_ch.pe_ready = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 67;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apply_coords(2'd3, 2'd0, 2'd1, 2'd2);
    offer_tick(make_tick(1'b0, '0, 1'b0, '0, 1'b0, 1'b0));
    offer_tick(make_tick(1'b1, '1, 1'b1, '1, 1'b0, 1'b0));
    offer_tick(make_tick(1'b1, '0, 1'b1, '0, 1'b0, 1'b0));
    for (int i = 0; i < 6; i++) begin
      offer_tick(make_tick(1'b1, ((i % 2) ? 22'h155555 : 22'h2AAAAA) ^ PW'(i), 1'b1,
                           ((i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA) ^ FLIT_BITS'(i),
                           1'b0, 1'b0));
    end
    // full: drop, then make room by dequeuing in the same tick
    offer_tick(make_tick(1'b1, 22'h3F0F0F, 1'b1, 32'hF0F0_F0F0, 1'b0, 1'b0));
    offer_tick(make_tick(1'b1, 22'h00FFFF, 1'b1, 32'h0F0F_0F0F, 1'b1, 1'b1));
    for (int i = 0; i < 9; i++) offer_tick(make_tick(1'b0, '0, 1'b0, '0, 1'b1, 1'b1));
    offer_tick(make_tick(1'b1, 22'h200000, 1'b1, 32'h8000_0001, 1'b1, 1'b1));
    offer_tick(make_tick(1'b0, '0, 1'b0, '0, 1'b1, 1'b0));
    offer_tick(make_tick(1'b0, '0, 1'b0, '0, 1'b0, 1'b1));
    end_burst();

    for (int chunk = 0; chunk < 6; chunk++) begin
      case (chunk / 2)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (chunk)
        0: apply_coords(2'd0, 2'd0, 2'd0, 2'd0);
        1: apply_coords(2'd3, 2'd3, 2'd3, 2'd3);
        default: apply_coords(2'($urandom_range(3)), 2'($urandom_range(3)),
                              2'($urandom_range(3)), 2'($urandom_range(3)));
      endcase
      if (chunk == 2 || chunk == 4) hold_request = 1'b1;
      for (int n = 0; n < 317; n++) begin
        if (n % 40 == 0) begin
          pv_pct = pct_levels[$urandom_range(2)];
          rv_pct = pct_levels[$urandom_range(2)];
          rr_pct = pct_levels[$urandom_range(2)];
          pr_pct = pct_levels[$urandom_range(2)];
        end
        t.pe_valid = ($urandom_range(99) < pv_pct);
        t.pe_data = PW'($urandom);
        t.router_valid = ($urandom_range(99) < rv_pct);
        t.flit_in = $urandom;
        t.router_ready = ($urandom_range(99) < rr_pct);
        t.pe_ready = ($urandom_range(99) < pr_pct);
        offer_tick(t);
      end
      end_burst();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
